/* sv/msem_pkg.sv */
// Package for the minimum-tracking stack: sizes, mode and status codes,
// and the controller/datapath command and status structs. No dependencies.
package msem_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int ENTRY_W     = WORD_W + 2;

    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_POP  = 2'd1;
    localparam logic [1:0] MODE_PEEK = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_PUSH_FULL = 2'd2;

    typedef struct packed {
        logic exec;    // apply the operation on the input ports
        logic finish;  // load the result register
    } msem_cmd_t;

    typedef struct packed {
        logic out_busy; // result register holds a result not yet taken
    } msem_stat_t;

endpackage

/* sv/min_stack_encoded_minimum_top.sv */
// Minimum-tracking stack of signed 32-bit values, 1024 entries deep. Each
// transfer (push, pop or peek) returns one result with the top and the
// running minimum after the operation, or -1 for both when empty, plus a
// status code. An operation is applied in the idle state and its result is
// formed in the finishing state, needed because the new top after a pop comes
// from the entry memory's registered read port. The next operation is taken
// while the previous result waits on m_ready; the finishing cycle stalls only
// while the result register is still occupied. Entries are stored encoded
// (2*value - minimum when a push lowers the minimum), 34 bits wide.
// Depends on msem_pkg, msem_ctrl and msem_datapath.
module min_stack_encoded_minimum_top
    import msem_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_mode,
    input  logic signed [WORD_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [WORD_W-1:0] m_top_value,
    output logic signed [WORD_W-1:0] m_min_value,
    output logic                     m_is_empty,
    output logic [1:0]               m_status
);

    msem_cmd_t  cmd;
    msem_stat_t stat;

    msem_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    msem_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_mode      (s_mode),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_top_value (m_top_value),
        .m_min_value (m_min_value),
        .m_is_empty  (m_is_empty),
        .m_status    (m_status)
    );

endmodule

/* sv/msem_ctrl.sv */
// Controller for the minimum-tracking stack: two-state sequencer.
// Depends on msem_pkg.
module msem_ctrl
    import msem_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  msem_stat_t stat,
    output msem_cmd_t  cmd
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_FINISH = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd.exec   = 1'b0;
        cmd.finish = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.exec   = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/msem_datapath.sv */
// Datapath for the minimum-tracking stack: entry memory, fill count,
// minimum, cached top entry and result register. Depends on msem_pkg.
module msem_datapath
    import msem_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  msem_cmd_t                cmd,
    output msem_stat_t               stat,
    input  logic [1:0]               s_mode,
    input  logic signed [WORD_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [WORD_W-1:0] m_top_value,
    output logic signed [WORD_W-1:0] m_min_value,
    output logic                     m_is_empty,
    output logic [1:0]               m_status
);

    logic [ENTRY_W-1:0] mem [STACK_DEPTH];

    logic [CNT_W-1:0]         fill_reg;
    logic [CNT_W-1:0]         fill_next;
    logic signed [WORD_W-1:0] min_reg;
    logic signed [WORD_W-1:0] min_next;
    logic signed [ENTRY_W-1:0] top_reg;
    logic signed [ENTRY_W-1:0] rd_data_reg;
    logic                     use_rd_reg;
    logic                     use_rd_next;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic                     m_valid_reg;

    logic                      is_push;
    logic                      is_pop;
    logic                      full;
    logic                      empty;
    logic signed [ENTRY_W-1:0] val_ext;
    logic signed [ENTRY_W-1:0] min_ext;
    logic signed [ENTRY_W-1:0] enc_entry;
    logic signed [ENTRY_W-1:0] push_entry;
    logic signed [ENTRY_W-1:0] restored;
    logic                      do_write;
    logic                      do_read;
    logic [CNT_W-1:0]          rd_cnt;
    logic signed [ENTRY_W-1:0] new_top;

    assign is_push = (s_mode == MODE_PUSH);
    assign is_pop  = (s_mode == MODE_POP);
    assign full    = (fill_reg == CNT_W'(STACK_DEPTH));
    assign empty   = (fill_reg == '0);

    assign val_ext   = ENTRY_W'(s_value);
    assign min_ext   = ENTRY_W'(min_reg);
    // 2*value - min when the pushed value undercuts the minimum
    assign enc_entry = {s_value[WORD_W-1], s_value, 1'b0} - min_ext;
    // previous minimum recovered from an encoded entry: 2*min - entry
    assign restored  = {min_reg[WORD_W-1], min_reg, 1'b0} - top_reg;

    always_comb begin
        fill_next   = fill_reg;
        min_next    = min_reg;
        status_next = status_reg;
        use_rd_next = use_rd_reg;
        push_entry  = val_ext;
        do_write    = 1'b0;
        do_read     = 1'b0;
        rd_cnt      = fill_reg - CNT_W'(2);
        if (cmd.exec) begin
            status_next = STATUS_OK;
            use_rd_next = 1'b0;
            if (is_push) begin
                if (full) begin
                    status_next = STATUS_PUSH_FULL;
                end else begin
                    do_write  = 1'b1;
                    fill_next = fill_reg + CNT_W'(1);
                    if (empty) begin
                        min_next = s_value;
                    end else if (s_value < min_reg) begin
                        push_entry = enc_entry;
                        min_next   = s_value;
                    end
                end
            end else if (is_pop) begin
                if (empty) begin
                    status_next = STATUS_POP_EMPTY;
                end else begin
                    fill_next = fill_reg - CNT_W'(1);
                    if (top_reg < min_ext) begin
                        min_next = restored[WORD_W-1:0];
                    end
                    // new top comes back from memory when one remains
                    if (fill_reg > CNT_W'(1)) begin
                        do_read     = 1'b1;
                        use_rd_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[fill_reg[ADDR_W-1:0]] <= push_entry;
        end
        if (do_read) begin
            rd_data_reg <= mem[rd_cnt[ADDR_W-1:0]];
        end
    end

    assign new_top = use_rd_reg ? rd_data_reg : top_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            min_reg     <= '0;
            use_rd_reg  <= 1'b0;
            status_reg  <= STATUS_OK;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg   <= fill_next;
            min_reg    <= min_next;
            use_rd_reg <= use_rd_next;
            status_reg <= status_next;
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            top_reg <= push_entry;
        end else if (cmd.finish) begin
            top_reg <= new_top;
        end
        if (cmd.finish) begin
            m_status <= status_reg;
            if (empty) begin
                m_top_value <= '1;
                m_min_value <= '1;
                m_is_empty  <= 1'b1;
            end else begin
                m_top_value <= (new_top < min_ext) ? min_reg : new_top[WORD_W-1:0];
                m_min_value <= min_reg;
                m_is_empty  <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign stat.out_busy = m_valid_reg && !m_ready;

endmodule

/* verif/min_stack_encoded_minimum_top_tb.sv */
// Self-checking testbench for min_stack_encoded_minimum_top. It holds a shadow stack that
// predicts each transfer's result, and it drives random idling and stalls on both channels.
// Depends on msem_pkg and the RTL of the top level.
`timescale 1ns / 1ps

module min_stack_encoded_minimum_top_tb;
    import msem_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;   // unused code, behaves as a peek

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;

    localparam int          RANDOM_ITEMS   = 1000;
    localparam int          RX_HOLD_CYCLES = 300;
    localparam int          TAIL_CYCLES    = 10;
    localparam int unsigned LIMIT_CYCLES   = 400000;
    localparam int          MAX_PRINTS     = 40;

    typedef struct packed {
        logic signed [WORD_W-1:0] top;
        logic signed [WORD_W-1:0] minimum;
        logic                     empty;
        logic [1:0]               status;
    } stack_view_t;

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_valid  = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_mode   = MODE_PEEK;
    logic signed [WORD_W-1:0] s_value  = '0;
    logic                     m_valid;
    logic                     m_ready  = 1'b0;
    logic signed [WORD_W-1:0] m_top_value;
    logic signed [WORD_W-1:0] m_min_value;
    logic                     m_is_empty;
    logic [1:0]               m_status;

    // shadow copy of the stack
    logic signed [ENTRY_W-1:0] shadow_entries [STACK_DEPTH];
    int unsigned               shadow_fill = 0;
    logic signed [WORD_W-1:0]  shadow_min  = '0;

    stack_view_t pending_views [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    logic        gaps_on        = 1'b1;
    logic        rx_hold        = 1'b0;
    event        rx_hold_start;

    min_stack_encoded_minimum_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_top_value (m_top_value),
        .m_min_value (m_min_value),
        .m_is_empty  (m_is_empty),
        .m_status    (m_status)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("[min_stack_encoded_minimum_top] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // Applies one operation to the shadow stack and returns the result it should give.
    function automatic stack_view_t next_stack_view(input logic [1:0] mode,
                                                    input logic signed [WORD_W-1:0] value);
        longint      v;
        longint      e;
        longint      stored;
        stack_view_t view;
        v = value;
        view.status = STATUS_OK;
        if (mode == MODE_PUSH) begin
            if (shadow_fill >= STACK_DEPTH) begin
                view.status = STATUS_PUSH_FULL;
            end else if (shadow_fill == 0) begin
                shadow_min = value;
                shadow_entries[0] = v[ENTRY_W-1:0];
                shadow_fill = 1;
            end else begin
                stored = v;
                if (v < longint'(shadow_min)) begin
                    // encode: 2*value - old minimum, always below the new minimum
                    stored = 2 * v - longint'(shadow_min);
                    shadow_min = value;
                end
                shadow_entries[shadow_fill] = stored[ENTRY_W-1:0];
                shadow_fill++;
            end
        end else if (mode == MODE_POP) begin
            if (shadow_fill == 0) begin
                view.status = STATUS_POP_EMPTY;
            end else begin
                e = shadow_entries[shadow_fill - 1];
                if (e < longint'(shadow_min)) begin
                    stored = 2 * longint'(shadow_min) - e;
                    shadow_min = stored[WORD_W-1:0];
                end
                shadow_fill--;
            end
        end
        if (shadow_fill == 0) begin
            view.top     = -1;
            view.minimum = -1;
            view.empty   = 1'b1;
        end else begin
            e = shadow_entries[shadow_fill - 1];
            view.top     = (e < longint'(shadow_min)) ? shadow_min : e[WORD_W-1:0];
            view.minimum = shadow_min;
            view.empty   = 1'b0;
        end
        return view;
    endfunction

    function automatic logic signed [WORD_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 0;
                    1:       return -1;
                    2:       return WORD_MIN + 1;
                    default: return WORD_MAX - 1;
                endcase
            end
            3, 4, 5: return $urandom_range(0, 40) - 20;   // narrow range, plenty of ties
            default: return $urandom();
        endcase
    endfunction

    // Entered at a clock edge; returns at the edge where the transfer happens, valid still high.
    task automatic send_op(input logic [1:0] mode, input logic signed [WORD_W-1:0] value);
        while (gaps_on && $urandom_range(0, 99) < 16) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_views.push_back(next_stack_view(mode, value));
    endtask

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else if (rx_hold)
            m_ready <= 1'b0;
        else if (gaps_on)
            m_ready <= ($urandom_range(0, 99) >= 16);
        else
            m_ready <= 1'b1;
    end

    // long receiver stall, counted here so the sender keeps offering meanwhile
    initial begin
        forever begin
            @(rx_hold_start);
            rx_hold <= 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge aclk);
            rx_hold <= 1'b0;
        end
    end

    always @(posedge aclk) begin : check_results
        stack_view_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_views.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = pending_views.pop_front();
                if (m_top_value !== want.top)
                    report_mismatch($sformatf("top_value %0d, expected %0d",
                                              m_top_value, want.top));
                if (m_min_value !== want.minimum)
                    report_mismatch($sformatf("min_value %0d, expected %0d",
                                              m_min_value, want.minimum));
                if (m_is_empty !== want.empty)
                    report_mismatch($sformatf("is_empty %0b, expected %0b",
                                              m_is_empty, want.empty));
                if (m_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_status, want.status));
            end
        end
    end

    task automatic test_directed_cases();
        int n;
        send_op(MODE_PEEK, 0);
        send_op(MODE_POP, 0);            // pop on empty is flagged
        send_op(MODE_SPARE, -1);
        send_op(MODE_PUSH, 5);           // push onto empty sets the minimum
        send_op(MODE_PUSH, 7);
        send_op(MODE_PUSH, 5);           // equal to minimum, stored plain
        send_op(MODE_PUSH, 3);
        send_op(MODE_PUSH, WORD_MIN);
        send_op(MODE_PEEK, WORD_MAX);
        send_op(MODE_SPARE, WORD_MAX);
        send_op(MODE_PUSH, WORD_MAX);
        for (n = 0; n < 7; n++)
            send_op(MODE_POP, WORD_MIN);
        send_op(MODE_PUSH, WORD_MAX);
        send_op(MODE_PUSH, WORD_MIN);    // widest encoded entry
        send_op(MODE_POP, 0);
        send_op(MODE_POP, 0);
        send_op(MODE_PUSH, -1);
        send_op(MODE_POP, 0);            // emptied: minimum kept inside, -1 reported
        send_op(MODE_PEEK, 0);
    endtask

    task automatic test_fill_to_full();
        int unsigned n;
        int unsigned pushes;
        pushes = STACK_DEPTH - shadow_fill + 3;
        for (n = 0; n < pushes; n++)
            send_op(MODE_PUSH, random_value());
        send_op(MODE_PEEK, 0);
        while (shadow_fill != 0)
            send_op(($urandom_range(0, 9) == 0) ? MODE_PEEK : MODE_POP, random_value());
        send_op(MODE_POP, random_value());
    endtask

    task automatic test_output_hold();
        int n;
        -> rx_hold_start;
        for (n = 0; n < 40; n++)
            send_op((n % 3 == 2) ? MODE_POP : MODE_PUSH, random_value());
    endtask

    task automatic test_random_mix();
        int         n;
        int         pick;
        int         push_cut;
        int         pop_cut;
        logic [1:0] mode;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 400)
                gaps_on <= 1'b0;         // stretch with no idling on either side
            if (n == 600)
                gaps_on <= 1'b1;
            // alternate push-heavy and pop-heavy phases so the depth wanders to empty and back
            push_cut = ((n / 150) % 2 == 0) ? 55 : 30;
            pop_cut  = push_cut + (((n / 150) % 2 == 0) ? 30 : 55);
            pick = $urandom_range(0, 99);
            if (pick < push_cut)
                mode = MODE_PUSH;
            else if (pick < pop_cut)
                mode = MODE_POP;
            else if (pick < 96)
                mode = MODE_PEEK;
            else
                mode = MODE_SPARE;
            send_op(mode, random_value());
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_fill_to_full();
        test_output_hold();
        test_random_mix();
        s_valid <= 1'b0;
        while (pending_views.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("[min_stack_encoded_minimum_top] OK");
        else
            $display("[min_stack_encoded_minimum_top] ERROR");
        $finish;
    end

endmodule
